// ===== rtl/core/gyi_pkg.sv =====
package gyi_pkg;

    // item kinds
    localparam logic [1:0] KIND_CALIB = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ZERO  = 2'd2;

    localparam int RAW_W   = 16;
    localparam int CORR_W  = 25;
    localparam int BIAS_W  = 25;
    localparam int SUM_W   = 24;
    localparam int LIMIT_W = 24;
    localparam int YAW_W   = 32;
    localparam int REL_W   = 31;

    localparam int CALIB_COUNT_DEF = 200;
    localparam logic [LIMIT_W-1:0] BIAS_LIMIT_RESET = 24'd20972;

    // 180 and 360 degrees in 2^-22 degree units
    localparam logic signed [YAW_W-1:0] DEG180 = 32'sd754974720;
    localparam logic signed [YAW_W-1:0] DEG360 = 32'sd1509949440;

    typedef struct packed {
        logic done;
        logic ok;
    } calib_stat_t;

    function automatic logic signed [YAW_W-1:0] wrap_once(input logic signed [YAW_W-1:0] a);
        logic signed [YAW_W-1:0] r;
        if (a > DEG180)
        begin
            r = a - DEG360;
        end
        else if (a < -DEG180)
        begin
            r = a + DEG360;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gyi_ifs.sv =====
interface gyi_sample_if
    import gyi_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [RAW_W-1:0] rate_raw;

    modport source (output valid, output kind, output rate_raw, input ready);
    modport sink (input valid, input kind, input rate_raw, output ready);
endinterface

interface gyi_result_if
    import gyi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [REL_W-1:0]  rel_yaw;
    logic signed [CORR_W-1:0] rate_corrected;
    logic                     calib_done;
    logic                     calib_ok;

    modport source (output valid, output rel_yaw, output rate_corrected,
                    output calib_done, output calib_ok, input ready);
    modport sink (input valid, input rel_yaw, input rate_corrected,
                  input calib_done, input calib_ok, output ready);
endinterface

// ===== rtl/core/gyi_calib.sv =====
module gyi_calib
    import gyi_pkg::*;
#(
    parameter int CALIB_COUNT = CALIB_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic signed [RAW_W-1:0]   raw,
    input  logic [LIMIT_W-1:0]        bias_limit,
    output logic signed [BIAS_W-1:0]  bias,
    output calib_stat_t               stat
);
    localparam int CNT_W = $clog2(CALIB_COUNT + 1);
    // reciprocal of the run length, exact for dividends below 2^31
    localparam int SHIFT = 31 + $clog2(CALIB_COUNT);
    localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(CALIB_COUNT) - 64'd1)
                                      / 64'(CALIB_COUNT);
    localparam logic [31:0] RECIP = RECIP64[31:0];
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CALIB_COUNT - 1);

    logic signed [SUM_W-1:0]  sum_reg, sum_next, sum_acc;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [BIAS_W-1:0] bias_reg, bias_next, bias_new;
    logic                     last;
    logic                     neg;
    logic [SUM_W-1:0]         mag;
    logic [SUM_W+31:0]        prod;
    logic [SUM_W-1:0]         quot;
    logic signed [BIAS_W-1:0] quot_s;

    always_comb
    begin
        sum_acc = sum_reg + SUM_W'(raw);
        last    = (cnt_reg == LAST_CNT);
        neg     = sum_acc[SUM_W-1];
        mag     = neg ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
        // |sum| * 256 / n, truncated
        prod    = (SUM_W + 32)'(mag) * (SUM_W + 32)'(RECIP);
        quot    = prod[SHIFT-8 +: SUM_W];
        quot_s  = $signed({1'b0, quot});
        bias_new = neg ? -quot_s : quot_s;

        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        bias_next = bias_reg;
        if (step)
        begin
            if (last)
            begin
                sum_next  = '0;
                cnt_next  = '0;
                bias_next = bias_new;
            end
            else
            begin
                sum_next = sum_acc;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        stat.done = step && last;
        stat.ok   = step && last && (quot <= bias_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            bias_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            bias_reg <= bias_next;
        end
    end

    assign bias = bias_reg;

endmodule

// ===== rtl/core/gyi_yaw.sv =====
module gyi_yaw
    import gyi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [1:0]                kind,
    input  logic signed [RAW_W-1:0]   raw,
    input  logic signed [BIAS_W-1:0]  bias,
    output logic signed [REL_W-1:0]   rel_yaw,
    output logic signed [CORR_W-1:0]  rate_corrected
);
    logic signed [YAW_W-1:0]  yaw_reg, yaw_next;
    logic signed [YAW_W-1:0]  off_reg, off_next;
    logic signed [CORR_W-1:0] raw_x, corr;
    logic signed [YAW_W-1:0]  corr_w, corr5, yaw_upd;
    logic signed [YAW_W-1:0]  rel_full;

    always_comb
    begin
        raw_x   = CORR_W'(raw);
        corr    = (raw_x <<< 8) - bias;
        corr_w  = YAW_W'(corr);
        // one lsb over 5 ms is 5 units of 2^-22 degree
        corr5   = (corr_w <<< 2) + corr_w;
        yaw_upd = wrap_once(yaw_reg + corr5);

        yaw_next       = yaw_reg;
        off_next       = off_reg;
        rate_corrected = '0;
        unique case (kind)
            KIND_RATE:
            begin
                yaw_next       = yaw_upd;
                rate_corrected = corr;
            end
            KIND_ZERO:
            begin
                off_next = yaw_reg;
            end
            default:
            begin
                yaw_next = yaw_reg;
            end
        endcase

        rel_full = wrap_once(yaw_next - off_next);
        rel_yaw  = rel_full[REL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg <= '0;
            off_reg <= '0;
        end
        else if (step)
        begin
            yaw_reg <= yaw_next;
            off_reg <= off_next;
        end
    end

endmodule

// ===== rtl/core/gyro_yaw_integrator_core.sv =====
// gyro yaw integrator
// samples channel (valid/ready): kind plus one signed 16-bit z gyro reading at 200 Hz.
//   kind 0 adds to the calibration run, kind 1 integrates the bias-corrected rate,
//   kind 2 latches the current yaw as the zero reference.
// results channel (valid/ready): one result per request, in order, with the
//   relative yaw wrapped to +-180 deg (2^-22 deg units), the corrected rate,
//   and calib_done / calib_ok on the request that ends a calibration run.
// cfg_wr_en / cfg_wr_data write bias_limit; write it only while the block is idle.
// a request accepted into the input register is computed and its result loaded into
//   the result register. throughput: one request per cycle while results.ready stays
//   high, set by the single compute stage between the input and result registers.
// when the receiver stalls, the result register holds and the input register
//   still takes one more request; after that samples.ready drops.
// reset clears yaw, offset, bias and the calibration run, and loads bias_limit
//   with 20972 (about 5 deg/s); both channels come up empty.
// CALIB_COUNT (1 to 255) sets the calibration run length.
module gyro_yaw_integrator_core
    import gyi_pkg::*;
#(
    parameter int CALIB_COUNT = CALIB_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    gyi_sample_if.sink         samples,
    gyi_result_if.source       results,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);
    logic                     in_v_reg, in_v_next;
    logic [1:0]               kind_reg;
    logic signed [RAW_W-1:0]  raw_reg;
    logic                     out_v_reg, out_v_next;
    logic signed [REL_W-1:0]  rel_reg;
    logic signed [CORR_W-1:0] corr_reg;
    calib_stat_t              stat_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    logic                     advance;
    logic                     take;
    logic                     calib_step;
    logic signed [BIAS_W-1:0] bias;
    calib_stat_t              stat;
    logic signed [REL_W-1:0]  rel_c;
    logic signed [CORR_W-1:0] corr_c;

    assign advance       = in_v_reg && (!out_v_reg || results.ready);
    assign samples.ready = !in_v_reg || advance;
    assign take          = samples.valid && samples.ready;
    assign calib_step    = advance && (kind_reg == KIND_CALIB);

    gyi_calib #(
        .CALIB_COUNT (CALIB_COUNT)
    ) u_calib (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (calib_step),
        .raw        (raw_reg),
        .bias_limit (limit_reg),
        .bias       (bias),
        .stat       (stat)
    );

    gyi_yaw u_yaw (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .kind           (kind_reg),
        .raw            (raw_reg),
        .bias           (bias),
        .rel_yaw        (rel_c),
        .rate_corrected (corr_c)
    );

    always_comb
    begin
        in_v_next = take || (in_v_reg && !advance);
        if (advance)
        begin
            out_v_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            limit_reg <= BIAS_LIMIT_RESET;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= samples.kind;
            raw_reg  <= samples.rate_raw;
        end
        if (advance)
        begin
            rel_reg  <= rel_c;
            corr_reg <= corr_c;
            stat_reg <= stat;
        end
    end

    assign results.valid          = out_v_reg;
    assign results.rel_yaw        = rel_reg;
    assign results.rate_corrected = corr_reg;
    assign results.calib_done     = stat_reg.done;
    assign results.calib_ok       = stat_reg.ok;

endmodule
